FILE: src/efe_pkg.sv
// ----------------------------------------------------------------------------
// efe_pkg
// Shared constants, command type and state encoding for the escaped frame
// encoder.
// ----------------------------------------------------------------------------
package efe_pkg;

  // frame limits
  localparam int MAX_BYTES   = 29;
  localparam int CNT_W       = 5;
  localparam int STORE_DEPTH = 2 * MAX_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int Q_AW   = $clog2(QDEPTH);

  // character codes
  localparam logic [7:0]  ESC_CHAR    = 8'h23;
  localparam logic [7:0]  DEL_CHAR    = 8'h7F;
  localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
  localparam logic [7:0]  LEN_BIAS    = 8'h20;
  localparam logic [7:0]  NEWLINE     = 8'h0A;
  localparam logic [31:0] MAGIC_RESET = 32'hDEADBEEF;

  // one classified payload byte
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       drop;
    logic       last;
  } cmd_t;

  // back end sequencer
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ESC2  = 7'b0000010,
    ST_MAGIC = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_DATA  = 7'b0100000,
    ST_NL    = 7'b1000000
  } state_t;

endpackage

FILE: src/efe_in_if.sv
// ----------------------------------------------------------------------------
// efe_in_if
// Payload byte channel: one raw byte and a last flag per transaction.
// ----------------------------------------------------------------------------
interface efe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

FILE: src/efe_out_if.sv
// ----------------------------------------------------------------------------
// efe_out_if
// Encoded frame channel: one output byte with frame end and overflow flags.
// ----------------------------------------------------------------------------
interface efe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       overflow;

  modport source (output valid, output out_byte, output frame_end, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input overflow,
                  output ready);
endinterface

FILE: src/efe_ram.sv
// ----------------------------------------------------------------------------
// efe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module efe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/efe_front.sv
// ----------------------------------------------------------------------------
// efe_front
// Accepts payload bytes, classifies them as plain, escaped or dropped and
// hands them to the command queue.
// ----------------------------------------------------------------------------
module efe_front (
  input  logic          clk,
  input  logic          rst_n,
  efe_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output efe_pkg::cmd_t q_cmd
);
  import efe_pkg::*;

  logic [CNT_W-1:0] acc_cnt_r;
  logic [CNT_W-1:0] acc_cnt_nxt;
  logic             full_frame;

  // take a byte whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // classify the incoming byte
  assign full_frame = acc_cnt_r >= CNT_W'(MAX_BYTES);

  always_comb begin
    q_cmd.data = in_ch.data_byte;
    q_cmd.esc  = (in_ch.data_byte < CTRL_LIMIT) || (in_ch.data_byte == ESC_CHAR) ||
                 (in_ch.data_byte == DEL_CHAR);
    q_cmd.drop = full_frame;
    q_cmd.last = in_ch.last;
  end

  // accepted byte count per frame
  always_comb begin
    acc_cnt_nxt = acc_cnt_r;
    if (q_push) begin
      if (in_ch.last) begin
        acc_cnt_nxt = '0;
      end else if (!full_frame) begin
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= '0;
    end else begin
      acc_cnt_r <= acc_cnt_nxt;
    end
  end

endmodule

FILE: src/efe_queue.sv
// ----------------------------------------------------------------------------
// efe_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module efe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output efe_pkg::cmd_t head_cmd
);
  import efe_pkg::*;

  cmd_t          mem_r [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full       = count_r == (Q_AW+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: src/efe_back.sv
// ----------------------------------------------------------------------------
// efe_back
// Writes escaped bytes into the frame store and, on the last byte, plays out
// magic word, length, stored bytes and newline through the output register.
// ----------------------------------------------------------------------------
module efe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  input  logic          q_valid,
  input  efe_pkg::cmd_t q_head,
  output logic          q_pop,
  efe_out_if.source     out_ch
);
  import efe_pkg::*;

  state_t              state_r, state_nxt;
  logic [STORE_AW-1:0] cnt_r, cnt_nxt;
  logic [STORE_AW-1:0] idx_r, idx_nxt;
  logic [1:0]          mag_idx_r, mag_idx_nxt;
  logic                drop_r, drop_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic [31:0]         magic_r, magic_nxt;
  logic                ov_r, ov_nxt;
  logic [7:0]          ob_r, ob_nxt;
  logic                fe_r, fe_nxt;
  logic                of_r, of_nxt;

  logic                we;
  logic [7:0]          wdata;
  logic                re;
  logic [7:0]          rdata;
  logic                slot_free;
  logic [31:0]         mag_shift;

  // frame store
  efe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r),
    .wdata (wdata),
    .re    (re),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // output register drive
  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = ob_r;
  assign out_ch.frame_end = fe_r;
  assign out_ch.overflow  = of_r;

  assign slot_free = !ov_r || out_ch.ready;
  assign mag_shift = magic_r >> {~mag_idx_r, 3'b000};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    mag_idx_nxt = mag_idx_r;
    drop_nxt    = drop_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    magic_nxt   = cfg_we ? cfg_wdata : magic_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    fe_nxt      = fe_r;
    of_nxt      = of_r;
    we          = 1'b0;
    wdata       = '0;
    re          = 1'b0;
    q_pop       = 1'b0;

    unique case (state_r)
      // take one command, write its first byte
      ST_IDLE: begin
        mag_idx_nxt = '0;
        if (q_valid) begin
          q_pop    = 1'b1;
          byte_nxt = q_head.data;
          last_nxt = q_head.last;
          if (q_head.drop) begin
            drop_nxt  = 1'b1;
            state_nxt = q_head.last ? ST_MAGIC : ST_IDLE;
          end else begin
            we      = 1'b1;
            wdata   = q_head.esc ? ESC_CHAR : q_head.data;
            cnt_nxt = cnt_r + 1'b1;
            if (q_head.esc) begin
              state_nxt = ST_ESC2;
            end else begin
              state_nxt = q_head.last ? ST_MAGIC : ST_IDLE;
            end
          end
        end
      end
      // second byte of an escape pair
      ST_ESC2: begin
        we        = 1'b1;
        wdata     = byte_r + ESC_CHAR;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_MAGIC : ST_IDLE;
      end
      // sync bytes, most significant first
      ST_MAGIC: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          ob_nxt      = mag_shift[7:0];
          fe_nxt      = 1'b0;
          of_nxt      = drop_r;
          mag_idx_nxt = mag_idx_r + 1'b1;
          if (mag_idx_r == 2'd3) begin
            state_nxt = ST_LEN;
          end
        end
      end
      // length byte
      ST_LEN: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = {{(8-STORE_AW){1'b0}}, cnt_r} + LEN_BIAS;
          fe_nxt    = 1'b0;
          of_nxt    = drop_r;
          idx_nxt   = '0;
          state_nxt = (cnt_r == '0) ? ST_NL : ST_RD;
        end
      end
      // fetch one stored byte
      ST_RD: begin
        re        = 1'b1;
        state_nxt = ST_DATA;
      end
      // send the fetched byte
      ST_DATA: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = rdata;
          fe_nxt    = 1'b0;
          of_nxt    = drop_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == cnt_r) ? ST_NL : ST_RD;
        end
      end
      // terminating newline, then a fresh frame
      ST_NL: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = NEWLINE;
          fe_nxt    = 1'b1;
          of_nxt    = drop_r;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      mag_idx_r <= '0;
      magic_r   <= MAGIC_RESET;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      mag_idx_r <= mag_idx_nxt;
      magic_r   <= magic_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ob_r   <= ob_nxt;
    fe_r   <= fe_nxt;
    of_r   <= of_nxt;
  end

endmodule

FILE: src/escaped_frame_encoder.sv
// ----------------------------------------------------------------------------
// escaped_frame_encoder
// Byte stuffing frame encoder: escapes and buffers payload bytes, then sends
// magic word, length, escaped payload and newline as one frame.
// ----------------------------------------------------------------------------
// Path: the last payload byte passes the queue entry, the idle state and, when
//   escaped, the escape state before the first frame byte is registered, once
//   earlier commands have drained. Store: one write per plain byte and two per
//   escaped byte; play-out sends magic word, length, stored bytes and newline,
//   with one store read plus one output load per stored byte.
// Reset: synchronous on rst_n; magic word returns to 0xDEADBEEF, no clear pass.
module escaped_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  efe_in_if.sink      in_ch,
  efe_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import efe_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // classify incoming bytes
  efe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  // decoupling queue
  efe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  // store and frame play-out
  efe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
